// File: rtl/ert_pkg.sv
// ----------------------------------------------------------------------------
// ert_pkg
// Shared types and constants of the echo request tracker.
// ----------------------------------------------------------------------------
package ert_pkg;

   localparam int SEQ_BITS       = 16;
   localparam int RTT_BITS       = 31;
   localparam int MIN_ICMP_BYTES = 8;
   localparam int MS_DIVISOR     = 1000;
   localparam int MS_SHIFT       = 3;
   localparam int MS_ODD         = MS_DIVISOR >> MS_SHIFT;
   localparam int MS_ODD_LOG     = 7;

   typedef enum logic [2:0] {
      STATUS_SENT    = 3'd0,
      STATUS_FULL    = 3'd1,
      STATUS_MATCH   = 3'd2,
      STATUS_SHORT   = 3'd3,
      STATUS_FOREIGN = 3'd4,
      STATUS_UNKNOWN = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      KIND_SENT  = 1'b0,
      KIND_REPLY = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [39:0] now_us;
      logic [11:0] total_length;
      logic [3:0]  header_words;
      logic [7:0]  reply_type;
      logic [15:0] reply_identifier;
      logic [15:0] reply_sequence;
   } request_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] sequence_out;
      logic [30:0] round_trip_ms;
      logic [15:0] sent_total;
      logic [15:0] received_total;
   } response_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DIVIDE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic scan_start;
      logic scan_step;
      logic found;
      logic div_start;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_send;
      logic reply_ok;
      logic hit;
      logic scan_exhausted;
      logic div_busy;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/ert_div.sv
// ----------------------------------------------------------------------------
// ert_div
// Reciprocal multiplier that turns microseconds into whole milliseconds.
// The time is shifted right by three and multiplied by a scaled reciprocal
// of 125, one 16-bit digit of the time per cycle, most significant first.
// ----------------------------------------------------------------------------
module ert_div #(
   parameter int W = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   output logic         busy,
   output logic [W-1:0] quotient
);
   import ert_pkg::*;

   localparam int N    = W - MS_SHIFT;
   localparam int MW   = N + 1;
   localparam int DIG  = 16;
   localparam int NDIG = (N + DIG - 1) / DIG;
   localparam int YW   = NDIG * DIG;
   localparam int PW   = MW + DIG;
   localparam int AW   = YW + MW;
   localparam int SH   = N + MS_ODD_LOG;
   localparam int CNTW = $clog2(NDIG + 1);
   localparam logic [SH:0]   SCALE      = {1'b1, {SH{1'b0}}};
   localparam logic [SH:0]   MAGIC_WIDE = (SCALE + (SH + 1)'(MS_ODD - 1)) /
                                          (SH + 1)'(MS_ODD);
   localparam logic [MW-1:0] MAGIC      = MAGIC_WIDE[MW-1:0];

   logic [YW-1:0]   y_ff, y_in;
   logic [AW-1:0]   acc_ff, acc_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [PW-1:0]   partial;

   always_comb begin
      partial = PW'(MAGIC) * PW'(y_ff[YW-1 -: DIG]);
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         y_in    = YW'(dividend[W-1:MS_SHIFT]);
         acc_in  = '0;
         cnt_in  = CNTW'(NDIG);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         y_in    = y_ff << DIG;
         acc_in  = (acc_ff << DIG) + AW'(partial);
         cnt_in  = cnt_ff - CNTW'(1);
         busy_in = cnt_ff != CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign busy     = busy_ff;
   assign quotient = W'(acc_ff >> SH);

endmodule

// File: rtl/ert_dpath.sv
// ----------------------------------------------------------------------------
// ert_dpath
// Slot table, request checks, counters, divider and response register.
// ----------------------------------------------------------------------------
module ert_dpath #(
   parameter int TABLE_ENTRIES = 128,
   parameter int TIME_BITS     = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [15:0]            csr_write_data,
   input  ert_pkg::request_type   req_payload,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output ert_pkg::response_type  rsp_payload,
   input  ert_pkg::dp_cmd_type    dp_cmd,
   output ert_pkg::dp_status_type dp_status
);
   import ert_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = AW + 1;
   localparam int EW = 1 + SEQ_BITS + TIME_BITS;
   localparam int QW = (TIME_BITS > RTT_BITS) ? TIME_BITS : RTT_BITS;
   localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES);

   logic [EW-1:0]       slot_mem [TABLE_ENTRIES];
   logic [EW-1:0]       rd_data_ff;
   logic [AW-1:0]       hit_idx_ff;
   logic [CW-1:0]       addr_ff, addr_in;
   logic                look_ff, look_in;
   logic                found_ff, found_in;
   request_type         req_ff;
   logic [15:0]         own_id_ff;
   logic [15:0]         send_cnt_ff, send_cnt_in;
   logic [15:0]         recv_cnt_ff, recv_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   response_type        rsp_ff, rsp_in;

   logic                rd_busy;
   logic [15:0]         rd_seq;
   logic [TIME_BITS-1:0] rd_time;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] diff;
   logic [6:0]          min_len;
   logic                is_short;
   logic                is_foreign;
   logic                is_send;
   logic                hit;
   logic                out_free;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [EW-1:0]       mem_wdata;
   logic                div_busy;
   logic [TIME_BITS-1:0] quotient;
   logic [QW-1:0]       q_ext;
   logic [RTT_BITS-1:0] rtt;

   assign rd_busy = rd_data_ff[EW-1];
   assign rd_seq  = rd_data_ff[EW-2 -: SEQ_BITS];
   assign rd_time = rd_data_ff[TIME_BITS-1:0];
   assign now_t   = TIME_BITS'(req_ff.now_us);
   assign diff    = now_t - rd_time;

   assign min_len    = 7'({req_ff.header_words, 2'b00}) + 7'(MIN_ICMP_BYTES);
   assign is_short   = req_ff.total_length < 12'(min_len);
   assign is_foreign = (req_ff.reply_type != 8'd0) ||
                       (req_ff.reply_identifier != own_id_ff);
   assign is_send    = req_ff.kind == KIND_SENT;
   assign hit        = look_ff && (is_send ? !rd_busy :
                                   (rd_busy && (rd_seq == req_ff.reply_sequence)));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   ert_div #(
      .W (TIME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dp_cmd.div_start),
      .dividend (diff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign q_ext = QW'(quotient);
   assign rtt   = ((q_ext >> RTT_BITS) != '0) ? '1 : q_ext[RTT_BITS-1:0];

   always_comb begin
      addr_in  = addr_ff;
      look_in  = look_ff;
      found_in = found_ff;
      if (dp_cmd.clear_step) begin
         addr_in = addr_ff + CW'(1);
      end
      if (dp_cmd.scan_start) begin
         addr_in = '0;
         look_in = 1'b0;
      end
      if (dp_cmd.scan_step) begin
         if (addr_ff != LAST) begin
            addr_in = addr_ff + CW'(1);
            look_in = 1'b1;
         end else begin
            look_in = 1'b0;
         end
      end
      if (dp_cmd.capture) begin
         found_in = 1'b0;
      end
      if (dp_cmd.found) begin
         found_in = 1'b1;
      end
   end

   always_comb begin
      mem_we    = dp_cmd.clear_step || (dp_cmd.commit && found_ff);
      mem_waddr = dp_cmd.clear_step ? addr_ff[AW-1:0] : hit_idx_ff;
      if (dp_cmd.clear_step) begin
         mem_wdata = '0;
      end else if (is_send) begin
         mem_wdata = {1'b1, send_cnt_ff, now_t};
      end else begin
         mem_wdata = {1'b0, rd_data_ff[EW-2:0]};
      end
   end

   always_comb begin
      send_cnt_in  = send_cnt_ff;
      recv_cnt_in  = recv_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (dp_cmd.commit && found_ff && is_send) begin
         send_cnt_in = send_cnt_ff + 16'd1;
      end
      if (dp_cmd.commit && found_ff && !is_send) begin
         recv_cnt_in = recv_cnt_ff + 16'd1;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (dp_cmd.commit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.sequence_out   = '0;
         rsp_in.round_trip_ms  = '0;
         rsp_in.sent_total     = send_cnt_in;
         rsp_in.received_total = recv_cnt_in;
         if (is_send) begin
            if (found_ff) begin
               rsp_in.status       = STATUS_SENT;
               rsp_in.sequence_out = send_cnt_ff;
            end else begin
               rsp_in.status = STATUS_FULL;
            end
         end else if (is_short) begin
            rsp_in.status = STATUS_SHORT;
         end else if (is_foreign) begin
            rsp_in.status = STATUS_FOREIGN;
         end else if (found_ff) begin
            rsp_in.status        = STATUS_MATCH;
            rsp_in.sequence_out  = req_ff.reply_sequence;
            rsp_in.round_trip_ms = rtt;
         end else begin
            rsp_in.status = STATUS_UNKNOWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (dp_cmd.scan_step && (addr_ff != LAST)) begin
         rd_data_ff <= slot_mem[addr_ff[AW-1:0]];
         hit_idx_ff <= addr_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         look_ff      <= 1'b0;
         found_ff     <= 1'b0;
         own_id_ff    <= '0;
         send_cnt_ff  <= '0;
         recv_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         look_ff      <= look_in;
         found_ff     <= found_in;
         send_cnt_ff  <= send_cnt_in;
         recv_cnt_ff  <= recv_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            own_id_ff <= csr_write_data;
         end
      end
      if (dp_cmd.capture) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      dp_status.clear_done     = addr_ff == LAST;
      dp_status.is_send        = is_send;
      dp_status.reply_ok       = !is_short && !is_foreign;
      dp_status.hit            = hit;
      dp_status.scan_exhausted = (addr_ff == LAST) && !look_ff;
      dp_status.div_busy       = div_busy;
      dp_status.out_free       = out_free;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> out_free)
      else $error("Response loaded while the previous one is still held.");

   a_write_port: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_step |-> !(dp_cmd.commit || dp_cmd.scan_step || dp_cmd.capture))
      else $error("Table clearing overlaps request processing.");

   a_step_hold: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.scan_step |-> !hit)
      else $error("Scan advanced past a matching slot.");

   a_rtt_ready: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.commit && found_ff && !is_send) |-> !div_busy)
      else $error("Round trip reported before the divider finished.");

endmodule

// File: rtl/ert_ctrl.sv
// ----------------------------------------------------------------------------
// ert_ctrl
// Sequencer for table clearing, slot scan, round trip division and response.
// ----------------------------------------------------------------------------
module ert_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ert_pkg::dp_status_type dp_status,
   output ert_pkg::dp_cmd_type    dp_cmd
);
   import ert_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (dp_status.clear_done) begin
               state_in = S_IDLE;
            end else begin
               dp_cmd.clear_step = 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_CHECK;
            end
         end
         S_CHECK: begin
            if (dp_status.is_send || dp_status.reply_ok) begin
               dp_cmd.scan_start = 1'b1;
               state_in          = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            if (dp_status.hit) begin
               dp_cmd.found = 1'b1;
               if (dp_status.is_send) begin
                  state_in = S_FINISH;
               end else begin
                  dp_cmd.div_start = 1'b1;
                  state_in         = S_DIVIDE;
               end
            end else if (dp_status.scan_exhausted) begin
               state_in = S_FINISH;
            end else begin
               dp_cmd.scan_step = 1'b1;
            end
         end
         S_DIVIDE: begin
            if (!dp_status.div_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (dp_status.out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("Accepted request did not start its checks.");

   a_clear_first: assert property (@(posedge clock)
      reset |=> (state_ff == S_CLEAR))
      else $error("Table clearing skipped after reset.");

   a_divide_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> $past(dp_cmd.div_start) || dp_status.div_busy ||
                                 ($past(state_ff) == S_DIVIDE))
      else $error("Divide state entered without starting the divider.");

endmodule

// File: rtl/echo_request_tracker.sv
// ----------------------------------------------------------------------------
// echo_request_tracker
// Table of outstanding echo requests with round trip measurement.
// ----------------------------------------------------------------------------
// After reset the block clears its slot table and takes no request until
// that pass is done; the identifier register can be written at any time.
// Requests are handled one at a time. A sent request scans the slot memory
// one slot per cycle for the first free slot, and a valid reply scans it for
// the first busy slot with its sequence. A matched reply then has the divider
// turn the elapsed microseconds into milliseconds. Short or foreign replies
// skip the scan. A finished response sits in an output register, so the next
// request can be taken while it waits.
// ----------------------------------------------------------------------------
module echo_request_tracker #(
   parameter int TABLE_ENTRIES = 128,
   parameter int TIME_BITS     = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ert_pkg::request_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ert_pkg::response_type rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data
);
   import ert_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ert_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   ert_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TIME_BITS     (TIME_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status)
   );

endmodule
